### rtl/vap_pkg.sv
`timescale 1ns / 1ps
package vap_pkg;

	// Default sizing
	localparam int VOICES_DEF = 16;
	localparam int OWNERS_DEF = 64;

	// Fixed field widths
	localparam int OP_W    = 2;
	localparam int OWNER_W = 6;
	localparam int DUR_W   = 16;
	localparam int MASK_W  = 16;
	localparam int ACT_W   = 2;
	localparam int VOICE_W = 4;
	localparam int REM_W   = 18;
	localparam int OWNER_SPAN = 64;

	// Operation codes
	localparam logic [OP_W-1:0] OP_PLAY = 2'd0;
	localparam logic [OP_W-1:0] OP_REL  = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK = 2'd2;

	// Action codes
	localparam logic [ACT_W-1:0] ACT_START = 2'd0;
	localparam logic [ACT_W-1:0] ACT_STOP  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_FREED = 2'd2;
	localparam logic [ACT_W-1:0] ACT_NONE  = 2'd3;

	// Remaining time floor
	localparam logic signed [REM_W:0] REM_MIN = -19'sd131072;

	// Per-field write enables of the voice record memory
	typedef struct packed {
		logic onext;
		logic oprev;
		logic anext;
		logic aprev;
		logic oid;
		logic rem;
	} vmask_t;

endpackage

### rtl/vap_vmem.sv
`timescale 1ns / 1ps
module vap_vmem import vap_pkg::*; #(
	parameter int VOICES = VOICES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic ren,
	input  logic [$clog2(VOICES)-1:0] raddr,
	output logic [$clog2(VOICES+1)-1:0] rd_onext,
	output logic [$clog2(VOICES+1)-1:0] rd_oprev,
	output logic [$clog2(VOICES+1)-1:0] rd_anext,
	output logic [$clog2(VOICES+1)-1:0] rd_aprev,
	output logic [OWNER_W-1:0] rd_oid,
	output logic signed [REM_W-1:0] rd_rem,
	input  logic we,
	input  logic [$clog2(VOICES)-1:0] waddr,
	input  vmask_t wmask,
	input  logic [$clog2(VOICES+1)-1:0] wd_onext,
	input  logic [$clog2(VOICES+1)-1:0] wd_oprev,
	input  logic [$clog2(VOICES+1)-1:0] wd_anext,
	input  logic [$clog2(VOICES+1)-1:0] wd_aprev,
	input  logic [OWNER_W-1:0] wd_oid,
	input  logic signed [REM_W-1:0] wd_rem
);
	localparam int VW = $clog2(VOICES+1);
	localparam logic [VW-1:0] NIL = VW'(VOICES);

	logic [VW-1:0] onext_m [VOICES];
	logic [VW-1:0] oprev_m [VOICES];
	logic [VW-1:0] anext_m [VOICES];
	logic [VW-1:0] aprev_m [VOICES];
	logic [OWNER_W-1:0] oid_m [VOICES];
	logic signed [REM_W-1:0] rem_m [VOICES];
	logic [VOICES-1:0] valid_q;

	// Entry written once means its stored record is live
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	// Field writes; first write to an entry fills unmasked fields with reset values
	always_ff @(posedge clk) begin
		if (we) begin
			if (wmask.onext) onext_m[waddr] <= wd_onext;
			else if (!valid_q[waddr]) onext_m[waddr] <= VW'(waddr) + VW'(1);
			if (wmask.oprev) oprev_m[waddr] <= wd_oprev;
			else if (!valid_q[waddr]) oprev_m[waddr] <= NIL;
			if (wmask.anext) anext_m[waddr] <= wd_anext;
			else if (!valid_q[waddr]) anext_m[waddr] <= NIL;
			if (wmask.aprev) aprev_m[waddr] <= wd_aprev;
			else if (!valid_q[waddr]) aprev_m[waddr] <= NIL;
			if (wmask.oid) oid_m[waddr] <= wd_oid;
			else if (!valid_q[waddr]) oid_m[waddr] <= '0;
			if (wmask.rem) rem_m[waddr] <= wd_rem;
			else if (!valid_q[waddr]) rem_m[waddr] <= '0;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (ren) begin
			if (valid_q[raddr]) begin
				rd_onext <= onext_m[raddr];
				rd_oprev <= oprev_m[raddr];
				rd_anext <= anext_m[raddr];
				rd_aprev <= aprev_m[raddr];
				rd_oid   <= oid_m[raddr];
				rd_rem   <= rem_m[raddr];
			end else begin
				rd_onext <= VW'(raddr) + VW'(1);
				rd_oprev <= NIL;
				rd_anext <= NIL;
				rd_aprev <= NIL;
				rd_oid   <= '0;
				rd_rem   <= '0;
			end
		end
	end

endmodule

### rtl/vap_hmem.sv
`timescale 1ns / 1ps
module vap_hmem import vap_pkg::*; #(
	parameter int VOICES = VOICES_DEF,
	parameter int HEADS  = OWNERS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic ren,
	input  logic [(HEADS > 1 ? $clog2(HEADS) : 1)-1:0] raddr,
	output logic [$clog2(VOICES+1)-1:0] rdata,
	input  logic we,
	input  logic [(HEADS > 1 ? $clog2(HEADS) : 1)-1:0] waddr,
	input  logic [$clog2(VOICES+1)-1:0] wdata
);
	localparam int VW = $clog2(VOICES+1);

	logic [VW-1:0] head_m [HEADS];
	logic [HEADS-1:0] valid_q;

	// Unwritten heads read as an empty list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) head_m[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (ren) rdata <= valid_q[raddr] ? head_m[raddr] : VW'(VOICES);
	end

endmodule

### rtl/voice_allocator_lru_steal.sv
`timescale 1ns / 1ps
// Voice pool allocator with oldest-voice stealing. One transaction is taken at a time;
// in_ready is high only while the sequencer is idle. Per-voice links, owner id and
// remaining time live in a single-port-read voice memory, owner list heads in a second
// memory, both with registered reads, so every pointer hop waits for a read.
// Play steals the oldest voice when none is free. Release frees the owner's voices one
// by one. Tick visits every voice in order and frees each stopped one whose time went below zero.
// Results leave through an output register and a one-deep pending stage, so the final
// result can carry last; the sequencer stalls when both are full, and in its final step
// whenever the output register is full.
// No clearing pass is needed after reset: valid bits give the reset contents.
module voice_allocator_lru_steal import vap_pkg::*; #(
	parameter int VOICES = VOICES_DEF,
	parameter int OWNERS = OWNERS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [OP_W-1:0] op,
	input  logic [OWNER_W-1:0] owner,
	input  logic [DUR_W-1:0] duration,
	input  logic [DUR_W-1:0] elapsed,
	input  logic [MASK_W-1:0] stopped_mask,
	output logic out_valid,
	input  logic out_ready,
	output logic [ACT_W-1:0] action,
	output logic [VOICE_W-1:0] voice,
	output logic [OWNER_W-1:0] voice_owner,
	output logic last
);
	localparam int IW = $clog2(VOICES);
	localparam int VW = $clog2(VOICES+1);
	localparam int HEADS = OWNERS < OWNER_SPAN ? OWNERS : OWNER_SPAN;
	localparam int HW = HEADS > 1 ? $clog2(HEADS) : 1;
	localparam logic [VW-1:0] NIL = VW'(VOICES);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_PF   = 5'd1;
	localparam logic [4:0] S_ST1  = 5'd2;
	localparam logic [4:0] S_ST2  = 5'd3;
	localparam logic [4:0] S_ST3  = 5'd4;
	localparam logic [4:0] S_PHRQ = 5'd5;
	localparam logic [4:0] S_PL1  = 5'd6;
	localparam logic [4:0] S_PL2  = 5'd7;
	localparam logic [4:0] S_PL3  = 5'd8;
	localparam logic [4:0] S_RH   = 5'd9;
	localparam logic [4:0] S_RRD  = 5'd10;
	localparam logic [4:0] S_RA   = 5'd11;
	localparam logic [4:0] S_TRD  = 5'd12;
	localparam logic [4:0] S_TA   = 5'd13;
	localparam logic [4:0] S_TU1  = 5'd14;
	localparam logic [4:0] S_TU2  = 5'd15;
	localparam logic [4:0] S_AG1  = 5'd16;
	localparam logic [4:0] S_AG2  = 5'd17;
	localparam logic [4:0] S_FRV  = 5'd18;
	localparam logic [4:0] S_FIN  = 5'd19;

	logic [4:0] state_q;
	logic [OP_W-1:0] op_q;
	logic [OWNER_W-1:0] own_q;
	logic [DUR_W-1:0] dur_q, el_q;
	logic [MASK_W-1:0] mask_q;
	logic [VW-1:0] free_head_q, oldest_q, newest_q;
	logic [VOICES-1:0] active_q;
	logic [VW-1:0] v_q, nx_q, po_q, na_q, pa_q, h_q;
	logic [OWNER_W-1:0] oid_q;
	logic [VW-1:0] guard_q;

	// Output register and one pending result
	logic out_valid_q, last_q;
	logic [ACT_W-1:0] act_q;
	logic [VOICE_W-1:0] voice_q;
	logic [OWNER_W-1:0] vown_q;
	logic pend_v_q;
	logic [ACT_W-1:0] pend_act_q;
	logic [VOICE_W-1:0] pend_voice_q;
	logic [OWNER_W-1:0] pend_own_q;

	// Memory ports
	logic v_ren, v_we, h_ren, h_we;
	logic [IW-1:0] v_raddr, v_waddr;
	vmask_t v_wmask;
	logic [VW-1:0] wd_onext, wd_oprev, wd_anext, wd_aprev;
	logic [OWNER_W-1:0] wd_oid;
	logic signed [REM_W-1:0] wd_rem;
	logic [VW-1:0] rd_onext, rd_oprev, rd_anext, rd_aprev;
	logic [OWNER_W-1:0] rd_oid;
	logic signed [REM_W-1:0] rd_rem;
	logic [HW-1:0] h_raddr, h_waddr;
	logic [VW-1:0] h_rdata, h_wdata;

	logic in_acc, oid_ok, out_free, gen_en, go, stopped;
	logic [ACT_W-1:0] gen_act;
	logic [VW-1:0] gen_voice;
	logic [OWNER_W-1:0] gen_own;
	logic signed [REM_W:0] diff;
	logic signed [REM_W-1:0] rem_new;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc = in_valid && in_ready;
	assign oid_ok = (32'(oid_q) < OWNERS);
	assign out_free = !out_valid_q || out_ready;
	assign go = (state_q == S_FIN) ? out_free : (!gen_en || !pend_v_q || out_free);

	assign out_valid = out_valid_q;
	assign action = act_q;
	assign voice = voice_q;
	assign voice_owner = vown_q;
	assign last = last_q;

	// Tick arithmetic on the record just read
	assign diff = {rd_rem[REM_W-1], rd_rem} - $signed({3'b000, el_q});
	assign rem_new = (diff < REM_MIN) ? REM_MIN[REM_W-1:0] : diff[REM_W-1:0];
	assign stopped = (32'(v_q) < MASK_W) && mask_q[4'(v_q)];

	// Memory port and result control per sequencer step
	always_comb begin
		v_ren = 1'b0; v_raddr = IW'(v_q);
		v_we = 1'b0; v_waddr = IW'(v_q); v_wmask = '0;
		wd_onext = nx_q; wd_oprev = po_q; wd_anext = na_q; wd_aprev = pa_q;
		wd_oid = own_q; wd_rem = rem_new;
		h_ren = 1'b0; h_raddr = HW'(own_q);
		h_we = 1'b0; h_waddr = HW'(own_q); h_wdata = NIL;
		gen_en = 1'b0; gen_act = ACT_STOP; gen_voice = v_q; gen_own = oid_q;
		unique case (state_q)
			S_IDLE: begin
				v_ren = in_acc;
				v_raddr = (free_head_q < NIL) ? IW'(free_head_q) : IW'(oldest_q);
				h_ren = in_acc;
				h_raddr = HW'(owner);
			end
			S_ST1: begin
				if (rd_anext < NIL) begin
					v_we = 1'b1; v_waddr = IW'(rd_anext); v_wmask.aprev = 1'b1; wd_aprev = NIL;
				end
			end
			S_ST2, S_TU1: begin
				if (po_q >= NIL) begin
					h_we = oid_ok; h_waddr = HW'(oid_q); h_wdata = nx_q;
				end else begin
					v_we = 1'b1; v_waddr = IW'(po_q); v_wmask.onext = 1'b1;
				end
			end
			S_ST3: begin
				gen_en = 1'b1;
				if (nx_q < NIL) begin
					v_we = go; v_waddr = IW'(nx_q); v_wmask.oprev = 1'b1;
				end
			end
			S_PHRQ: h_ren = 1'b1;
			S_PL1: begin
				v_we = 1'b1; v_wmask = '1;
				wd_onext = h_rdata; wd_oprev = NIL; wd_anext = NIL; wd_aprev = newest_q;
				wd_rem = $signed({2'b00, dur_q});
				h_we = 1'b1; h_wdata = v_q;
			end
			S_PL2: begin
				if (h_q < NIL) begin
					v_we = 1'b1; v_waddr = IW'(h_q); v_wmask.oprev = 1'b1; wd_oprev = v_q;
				end
			end
			S_PL3: begin
				gen_en = 1'b1; gen_act = ACT_START; gen_own = own_q;
				if (newest_q < NIL) begin
					v_we = go; v_waddr = IW'(newest_q); v_wmask.anext = 1'b1; wd_anext = v_q;
				end
			end
			S_RRD: begin
				if (v_q < NIL && 32'(guard_q) < VOICES) v_ren = 1'b1;
				else h_we = 1'b1;
			end
			S_TRD: v_ren = (v_q < NIL) && active_q[IW'(v_q)];
			S_TA: begin
				v_we = 1'b1; v_wmask.rem = 1'b1;
			end
			S_TU2: begin
				if (nx_q < NIL) begin
					v_we = 1'b1; v_waddr = IW'(nx_q); v_wmask.oprev = 1'b1;
				end
			end
			S_AG1: begin
				if (oldest_q != v_q && pa_q < NIL) begin
					v_we = 1'b1; v_waddr = IW'(pa_q); v_wmask.anext = 1'b1;
				end
			end
			S_AG2: begin
				if (newest_q != v_q && na_q < NIL) begin
					v_we = 1'b1; v_waddr = IW'(na_q); v_wmask.aprev = 1'b1;
				end
			end
			S_FRV: begin
				gen_en = 1'b1;
				gen_act = (op_q == OP_TICK) ? ACT_FREED : ACT_STOP;
				v_we = go; v_wmask.onext = 1'b1; wd_onext = free_head_q;
			end
			default: begin
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			free_head_q <= '0;
			oldest_q <= NIL;
			newest_q <= NIL;
			active_q <= '0;
			out_valid_q <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			if (out_ready) out_valid_q <= 1'b0;
			if (gen_en && go) begin
				if (pend_v_q) begin
					out_valid_q <= 1'b1;
					act_q <= pend_act_q; voice_q <= pend_voice_q;
					vown_q <= pend_own_q; last_q <= 1'b0;
				end
				pend_v_q <= 1'b1;
				pend_act_q <= gen_act;
				pend_voice_q <= VOICE_W'(gen_voice);
				pend_own_q <= gen_own;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						op_q <= op; own_q <= owner; dur_q <= duration;
						el_q <= elapsed; mask_q <= stopped_mask;
						if (op == OP_PLAY && 32'(owner) < OWNERS) begin
							if (free_head_q < NIL) begin
								v_q <= free_head_q; state_q <= S_PF;
							end else if (oldest_q < NIL) begin
								v_q <= oldest_q; state_q <= S_ST1;
							end else begin
								state_q <= S_FIN;
							end
						end else if (op == OP_REL && 32'(owner) < OWNERS) begin
							state_q <= S_RH;
						end else if (op == OP_TICK) begin
							v_q <= '0; state_q <= S_TRD;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_PF: begin
					free_head_q <= rd_onext;
					active_q[IW'(v_q)] <= 1'b1;
					state_q <= S_PHRQ;
				end
				S_ST1: begin
					nx_q <= rd_onext; po_q <= rd_oprev; oid_q <= rd_oid;
					oldest_q <= rd_anext;
					if (rd_anext >= NIL) newest_q <= NIL;
					state_q <= S_ST2;
				end
				S_ST2: state_q <= S_ST3;
				S_ST3: if (go) state_q <= S_PHRQ;
				S_PHRQ: state_q <= S_PL1;
				S_PL1: begin
					h_q <= h_rdata;
					state_q <= S_PL2;
				end
				S_PL2: state_q <= S_PL3;
				S_PL3: begin
					if (go) begin
						if (newest_q >= NIL) oldest_q <= v_q;
						newest_q <= v_q;
						state_q <= S_FIN;
					end
				end
				S_RH: begin
					v_q <= h_rdata; guard_q <= '0;
					state_q <= S_RRD;
				end
				S_RRD: state_q <= v_ren ? S_RA : S_FIN;
				S_RA: begin
					nx_q <= rd_onext; pa_q <= rd_aprev; na_q <= rd_anext; oid_q <= rd_oid;
					state_q <= S_AG1;
				end
				S_TRD: begin
					if (v_q >= NIL) state_q <= S_FIN;
					else if (v_ren) state_q <= S_TA;
					else v_q <= v_q + VW'(1);
				end
				S_TA: begin
					nx_q <= rd_onext; po_q <= rd_oprev; na_q <= rd_anext;
					pa_q <= rd_aprev; oid_q <= rd_oid;
					if (rem_new[REM_W-1] && stopped) begin
						state_q <= S_TU1;
					end else begin
						v_q <= v_q + VW'(1); state_q <= S_TRD;
					end
				end
				S_TU1: state_q <= S_TU2;
				S_TU2: state_q <= S_AG1;
				S_AG1: begin
					if (oldest_q == v_q) oldest_q <= na_q;
					state_q <= S_AG2;
				end
				S_AG2: begin
					if (newest_q == v_q) newest_q <= pa_q;
					state_q <= S_FRV;
				end
				S_FRV: begin
					if (go) begin
						active_q[IW'(v_q)] <= 1'b0;
						free_head_q <= v_q;
						if (op_q == OP_TICK) begin
							v_q <= v_q + VW'(1); state_q <= S_TRD;
						end else begin
							v_q <= nx_q; guard_q <= guard_q + VW'(1); state_q <= S_RRD;
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						last_q <= 1'b1;
						act_q <= pend_v_q ? pend_act_q : ACT_NONE;
						voice_q <= pend_v_q ? pend_voice_q : '0;
						vown_q <= pend_v_q ? pend_own_q : '0;
						pend_v_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	vap_vmem #(.VOICES(VOICES)) u_vmem (
		.clk(clk), .arst_n(arst_n),
		.ren(v_ren), .raddr(v_raddr),
		.rd_onext(rd_onext), .rd_oprev(rd_oprev), .rd_anext(rd_anext),
		.rd_aprev(rd_aprev), .rd_oid(rd_oid), .rd_rem(rd_rem),
		.we(v_we), .waddr(v_waddr), .wmask(v_wmask),
		.wd_onext(wd_onext), .wd_oprev(wd_oprev), .wd_anext(wd_anext),
		.wd_aprev(wd_aprev), .wd_oid(wd_oid), .wd_rem(wd_rem)
	);

	vap_hmem #(.VOICES(VOICES), .HEADS(HEADS)) u_hmem (
		.clk(clk), .arst_n(arst_n),
		.ren(h_ren), .raddr(h_raddr), .rdata(h_rdata),
		.we(h_we), .waddr(h_waddr), .wdata(h_wdata)
	);

	// Reads are only issued in steps that write nothing to the voice memory
	a_no_rw: assert property (@(posedge clk) disable iff (!arst_n) !(v_ren && v_we))
		else $error("voice memory read and write in one cycle");

	// Pending result is drained before a new transaction is taken
	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_v_q)
		else $error("pending result left at idle");

	// Pending result only clears in the final step
	a_pend_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(pend_v_q) |-> $past(state_q) == S_FIN)
		else $error("pending result dropped");

	// Every transaction ends with a last result
	a_fin_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_free) |=> (out_valid_q && last_q))
		else $error("final result missing");

endmodule
